// ===== rtl/uvr_pkg.sv =====
// Shared types and codes for the unique value recorder.
// Holds the result outcome codes and the sequencer state type; no dependencies.
package uvr_pkg;

  typedef logic [2:0] outcome_t;

  localparam outcome_t OUT_STORED    = 3'd0;
  localparam outcome_t OUT_PRESENT   = 3'd1;
  localparam outcome_t OUT_ZERO      = 3'd2;
  localparam outcome_t OUT_FULL      = 3'd3;
  localparam outcome_t OUT_READ_FAIL = 3'd4;

  localparam int CAP_W     = 9;
  localparam int CAP_RESET = 256;

  typedef enum logic [0:0] {
    S_IDLE,
    S_SEARCH
  } state_t;

endpackage

// ===== rtl/unique_value_recorder_unit.sv =====
// Top level of the unique value recorder: value table, linear search sequencer and
// the APB-style capacity register. Depends on uvr_pkg.
//
// Channel   Direction  Handshake                          Payload
// input     in         start & !busy accepts              in_register_value, in_read_ok
// result    out        out_valid, one cycle, no backpress out_outcome, out_slot,
//                                                         out_stored_count, out_hits_seen
// config    in/out     psel & penable & pwrite & pready   paddr, pwdata, prdata
//
// A hit that is skipped (table full, read failed, zero value) or that lands in an
// empty table is decided in its accept cycle and its result follows in the next
// cycle; busy stays low. Otherwise the block walks the N stored entries with one
// memory read and one 64-bit compare per cycle; busy stays high until the search
// ends, so the next transaction waits for it. The single table read port sets this
// compare rate. Reset is synchronous and active low; it clears the counters and
// restores the capacity to 256. The table itself is not swept: only slots below
// the distinct count are ever compared. The receiver cannot stall, so results are
// never held.
module unique_value_recorder_unit
  import uvr_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_register_value,
  input  logic        in_read_ok,
  // result transactions
  output logic        out_valid,
  output logic [2:0]  out_outcome,
  output logic [7:0]  out_slot,
  output logic [8:0]  out_stored_count,
  output logic [31:0] out_hits_seen,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Address width of the table and width of a count that can reach the depth.
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  // Width in which the count and the capacity register can be compared.
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [1:0] ADDR_CAPACITY = 2'd0;

  state_t state_r, state_nxt;

  logic [CAP_W-1:0] cap_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [31:0]      hits_r, hits_nxt;
  logic [63:0]      value_r, value_nxt;
  logic [CW-1:0]    addr_r, addr_nxt;
  logic [CW-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic             pend_r, pend_nxt;
  logic [63:0]      rdata_r;

  logic             out_valid_r, out_valid_nxt;
  outcome_t         out_outcome_r, out_outcome_nxt;
  logic [7:0]       out_slot_r, out_slot_nxt;
  logic [8:0]       out_count_r, out_count_nxt;
  logic [31:0]      out_hits_r, out_hits_nxt;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [63:0]      mem_wdata;

  logic             accept;
  logic             table_full;
  logic             search_match;
  logic             search_last;
  logic [31:0]      slot_ext;
  logic [31:0]      count_ext;

  logic [63:0]      mem [TABLE_DEPTH];

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // The effective capacity is the register saturated at the table depth, so the
  // table is full when the count reaches either bound.
  assign table_full = (XW'(count_r) >= XW'(cap_r)) ||
                      (XW'(count_r) >= XW'(TABLE_DEPTH));

  // Search compare: read data of the slot issued in the previous cycle.
  assign search_match = pend_r && (rdata_r == value_r);
  assign search_last  = pend_r && (cmp_idx_r == count_r - CW'(1));

  // Configuration register write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(CAP_RESET);
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? {{(32 - CAP_W){1'b0}}, cap_r} : 32'd0;

  // Next state of the search sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && !table_full && in_read_ok && (in_register_value != 64'd0) &&
            (count_r != '0)) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (search_match || search_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory write and result values.
  always_comb begin
    count_nxt       = count_r;
    hits_nxt        = hits_r;
    value_nxt       = value_r;
    addr_nxt        = addr_r;
    cmp_idx_nxt     = cmp_idx_r;
    pend_nxt        = pend_r;
    out_valid_nxt   = 1'b0;
    out_outcome_nxt = out_outcome_r;
    out_slot_nxt    = out_slot_r;
    out_count_nxt   = out_count_r;
    out_hits_nxt    = out_hits_r;
    mem_we          = 1'b0;
    mem_waddr       = count_r[AW-1:0];
    mem_wdata       = value_r;
    slot_ext        = 32'd0;
    count_ext       = 32'(count_r);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          hits_nxt     = hits_r + 32'd1;
          value_nxt    = in_register_value;
          out_hits_nxt = hits_r + 32'd1;
          if (table_full) begin
            out_valid_nxt   = 1'b1;
            out_outcome_nxt = OUT_FULL;
          end else if (!in_read_ok) begin
            out_valid_nxt   = 1'b1;
            out_outcome_nxt = OUT_READ_FAIL;
          end else if (in_register_value == 64'd0) begin
            out_valid_nxt   = 1'b1;
            out_outcome_nxt = OUT_ZERO;
          end else if (count_r == '0) begin
            // Empty table: nothing to search, store straight into slot zero.
            mem_we          = 1'b1;
            mem_wdata       = in_register_value;
            count_nxt       = CW'(1);
            count_ext       = 32'd1;
            out_valid_nxt   = 1'b1;
            out_outcome_nxt = OUT_STORED;
          end else begin
            addr_nxt = '0;
            pend_nxt = 1'b0;
          end
          out_slot_nxt  = slot_ext[7:0];
          out_count_nxt = count_ext[8:0];
        end
      end
      S_SEARCH: begin
        if (search_match) begin
          slot_ext        = 32'(cmp_idx_r);
          out_valid_nxt   = 1'b1;
          out_outcome_nxt = OUT_PRESENT;
          out_slot_nxt    = slot_ext[7:0];
          out_count_nxt   = count_ext[8:0];
          out_hits_nxt    = hits_r;
        end else if (search_last) begin
          // No match in the stored entries: append at the next free slot.
          mem_we          = 1'b1;
          slot_ext        = 32'(count_r);
          count_nxt       = count_r + CW'(1);
          count_ext       = 32'(count_r + CW'(1));
          out_valid_nxt   = 1'b1;
          out_outcome_nxt = OUT_STORED;
          out_slot_nxt    = slot_ext[7:0];
          out_count_nxt   = count_ext[8:0];
          out_hits_nxt    = hits_r;
        end else begin
          pend_nxt    = 1'b1;
          cmp_idx_nxt = addr_r;
          addr_nxt    = addr_r + CW'(1);
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      hits_r      <= 32'd0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      hits_r      <= hits_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    value_r       <= value_nxt;
    addr_r        <= addr_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_slot_r    <= out_slot_nxt;
    out_count_r   <= out_count_nxt;
    out_hits_r    <= out_hits_nxt;
  end

  // Value table: one write port, one registered read port. The read address runs
  // ahead of the compare, since the read data is registered.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[addr_r[AW-1:0]];
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = out_outcome_r;
  assign out_slot         = out_slot_r;
  assign out_stored_count = out_count_r;
  assign out_hits_seen    = out_hits_r;

  // A search is only started on a nonempty table.
  a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> count_r != '0)
    else $error("search running on an empty table");

  // The read address never runs more than one slot past the stored entries.
  a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> addr_r <= count_r)
    else $error("search address beyond distinct count");

  // Results leave from idle or on the way back to idle, never in the middle of a search.
  a_no_result_mid_search: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> !out_valid_r)
    else $error("result strobe during a search");

  // Every accepted transaction bumps the hit counter by one.
  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> hits_r == $past(hits_r) + 32'd1)
    else $error("hit counter did not advance");

  // A new value grows the distinct count by exactly one.
  a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> count_r == $past(count_r) + CW'(1))
    else $error("distinct count out of step with table writes");

endmodule

// ===== sim/uvr_hit_checker.sv =====
`timescale 1ns / 100ps
// Self-checking monitor for the unique value recorder: watches hits, capacity writes and results.
// Predicts every result from its own copy of the table and counters. Depends on uvr_pkg.
module uvr_hit_checker
  import uvr_pkg::*;
#(
  parameter int         TABLE_DEPTH = 256,
  parameter logic [1:0] CAP_ADDR    = 2'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] in_register_value,
  input  logic        in_read_ok,
  input  logic        out_valid,
  input  logic [2:0]  out_outcome,
  input  logic [7:0]  out_slot,
  input  logic [8:0]  out_stored_count,
  input  logic [31:0] out_hits_seen,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_results
);

  typedef struct packed {
    outcome_t    outcome;
    logic [7:0]  slot;
    logic [8:0]  stored;
    logic [31:0] hits;
  } hit_result_t;

  logic [63:0]  value_table [TABLE_DEPTH];
  int unsigned  stored_total = 0;
  logic [31:0]  hit_total    = '0;
  logic [8:0]   capacity_reg = 9'(CAP_RESET);
  int           mismatches   = 0;
  hit_result_t  expected_results [$];

  assign fail_count = mismatches;

  // Updates the table and counters for one hit and returns the result it must produce.
  function automatic hit_result_t record_hit(input logic [63:0] value, input logic ok);
    int unsigned limit;
    logic        found;
    hit_result_t res;
    limit     = (capacity_reg > TABLE_DEPTH) ? TABLE_DEPTH : capacity_reg;
    hit_total = hit_total + 32'd1;
    found     = 1'b0;
    res.slot  = '0;
    if (stored_total >= limit) begin
      res.outcome = OUT_FULL;
    end else if (!ok) begin
      res.outcome = OUT_READ_FAIL;
    end else if (value == '0) begin
      res.outcome = OUT_ZERO;
    end else begin
      for (int i = 0; i < stored_total && !found; i++) begin
        if (value_table[i] == value) begin
          found    = 1'b1;
          res.slot = 8'(i);
        end
      end
      if (found) begin
        res.outcome = OUT_PRESENT;
      end else begin
        res.outcome               = OUT_STORED;
        res.slot                  = 8'(stored_total);
        value_table[stored_total] = value;
        stored_total++;
      end
    end
    res.stored = 9'(stored_total);
    res.hits   = hit_total;
    return res;
  endfunction

  always @(posedge clk) begin
    hit_result_t want;
    if (!rst_n) begin
      stored_total = 0;
      hit_total    = '0;
      capacity_reg = 9'(CAP_RESET);
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: outcome %0d slot %0d", out_outcome, out_slot);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_outcome !== want.outcome) begin
            $error("outcome: expected %0d, actual %0d", want.outcome, out_outcome);
            mismatches++;
          end
          if (out_slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, out_slot);
            mismatches++;
          end
          if (out_stored_count !== want.stored) begin
            $error("stored_count: expected %0d, actual %0d", want.stored, out_stored_count);
            mismatches++;
          end
          if (out_hits_seen !== want.hits) begin
            $error("hits_seen: expected %0d, actual %0d", want.hits, out_hits_seen);
            mismatches++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
        capacity_reg = pwdata[8:0];
      end
      if (start && !busy) begin
        expected_results.push_back(record_hit(in_register_value, in_read_ok));
      end
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the unique value recorder: clock, reset, hit and capacity stimulus, verdict.
// Depends on uvr_pkg, unique_value_recorder_unit and uvr_hit_checker.
module tb_top;

  localparam int         DEPTH         = 256;
  localparam logic [1:0] CAPACITY_ADDR = 2'd0;
  // The slowest legal run is roughly 1460 hits, each with a full search of the table
  // and a gap before it; the limit leaves a wide margin over that run.
  localparam int         CYCLE_LIMIT   = 2_000_000;

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        start             = 1'b0;
  logic        busy;
  logic [63:0] in_register_value = '0;
  logic        in_read_ok        = 1'b0;
  logic        out_valid;
  logic [2:0]  out_outcome;
  logic [7:0]  out_slot;
  logic [8:0]  out_stored_count;
  logic [31:0] out_hits_seen;
  logic        psel              = 1'b0;
  logic        penable           = 1'b0;
  logic        pwrite            = 1'b0;
  logic [1:0]  paddr             = '0;
  logic [31:0] pwdata            = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending_results;
  int          cycle_count       = 0;

  // Values sent earlier with a good read; replaying them drives the search to hits
  // at every depth of the table instead of only ever appending.
  logic [63:0] seen_values [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  unique_value_recorder_unit #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_register_value(in_register_value),
    .in_read_ok       (in_read_ok),
    .out_valid        (out_valid),
    .out_outcome      (out_outcome),
    .out_slot         (out_slot),
    .out_stored_count (out_stored_count),
    .out_hits_seen    (out_hits_seen),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  uvr_hit_checker #(
    .TABLE_DEPTH(DEPTH),
    .CAP_ADDR   (CAPACITY_ADDR)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_register_value(in_register_value),
    .in_read_ok       (in_read_ok),
    .out_valid        (out_valid),
    .out_outcome      (out_outcome),
    .out_slot         (out_slot),
    .out_stored_count (out_stored_count),
    .out_hits_seen    (out_hits_seen),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .fail_count       (fail_count),
    .pending_results  (pending_results)
  );

  // Offers one hit after the given number of idle cycles and returns once the block
  // has taken the transaction. Start is left high so that a hit with no gap follows
  // back to back; the next negedge either replaces the data or drops start.
  task automatic send_hit(input logic [63:0] value, input logic ok, input int gap);
    for (int k = 0; k < gap; k++) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start             <= 1'b1;
    in_register_value <= value;
    in_read_ok        <= ok;
    do @(posedge clk); while (busy);
  endtask

  // Stops offering hits and waits until every predicted result has come back and the
  // block has left its search. Every hit produces a result, so nothing else is pending.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results != 0 || busy) @(negedge clk);
  endtask

  // Two-phase register write; only ever called while the block is idle.
  task automatic write_capacity(input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hard stop in case the block stops accepting hits or stops producing results.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [63:0] value;
    logic        ok;
    int          pick;
    int          phase_len;
    logic [31:0] cap_word;
    bit          idle_on;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A capacity of four keeps the table small enough to reach the
    // full condition within a handful of hits.
    write_capacity(32'd4);
    // A failed read is reported as such even when the value is zero, so the read
    // test ranks ahead of the zero test.
    send_hit(64'h0, 1'b0, $urandom_range(0, 4));
    send_hit(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, $urandom_range(0, 4));
    send_hit(64'h0, 1'b1, $urandom_range(0, 4));
    // Fill the four slots with extreme and alternating patterns, with repeats in between.
    send_hit(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, $urandom_range(0, 4));
    send_hit(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, $urandom_range(0, 4));
    send_hit(64'h1, 1'b1, $urandom_range(0, 4));
    send_hit(64'h1, 1'b1, $urandom_range(0, 4));
    send_hit(64'h8000_0000_0000_0000, 1'b1, $urandom_range(0, 4));
    send_hit(64'h5555_5555_5555_5555, 1'b1, $urandom_range(0, 4));
    // The table is now at capacity: the full test outranks everything, including a
    // failed read, a zero value and a value that is already stored.
    send_hit(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, $urandom_range(0, 4));
    send_hit(64'h0, 1'b0, $urandom_range(0, 4));
    send_hit(64'h0, 1'b1, $urandom_range(0, 4));
    send_hit(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, $urandom_range(0, 4));

    // Zero capacity turns every hit into a full report.
    wait_idle();
    write_capacity(32'd0);
    send_hit(64'h2, 1'b1, $urandom_range(0, 4));
    send_hit(64'h0, 1'b0, $urandom_range(0, 4));

    // Capacity lowered below the number already stored.
    wait_idle();
    write_capacity(32'd2);
    send_hit(64'h1, 1'b1, $urandom_range(0, 4));

    // All ones in the data word: the register keeps nine bits, 511, which saturates
    // at the table depth. The first slots become searchable again.
    wait_idle();
    write_capacity(32'hFFFF_FFFF);
    send_hit(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, $urandom_range(0, 4));
    send_hit(64'h5555_5555_5555_5555, 1'b1, $urandom_range(0, 4));
    send_hit(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, $urandom_range(0, 4));
    send_hit(64'h0, 1'b1, $urandom_range(0, 4));
    send_hit(64'h1234_5678_9ABC_DEF0, 1'b0, $urandom_range(0, 4));

    // Random part. Each phase sets a new capacity, growing so that the table fills in
    // steps all the way to its depth, then a short phase with the capacity cut far
    // below the stored count, then the reset value again. Unused upper bits of the
    // data word are random.
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      cap_word = $urandom;
      case (p)
        0:       cap_word[8:0] = 9'd24;
        1:       cap_word[8:0] = 9'd64;
        2:       cap_word[8:0] = 9'd128;
        3:       cap_word[8:0] = 9'd200;
        4:       cap_word[8:0] = 9'd511;
        5:       cap_word[8:0] = 9'd300;
        6:       cap_word[8:0] = 9'($urandom_range(0, 20));
        default: cap_word[8:0] = 9'd256;
      endcase
      write_capacity(cap_word);
      phase_len = (p == 6) ? 40 : 200;
      // Some phases run with no gaps at all between hits.
      idle_on = ($urandom_range(0, 2) != 0);
      for (int n = 0; n < phase_len; n++) begin
        // Now and then let the block drain completely before the next hit.
        if ($urandom_range(0, 39) == 0) begin
          wait_idle();
        end
        pick  = $urandom_range(0, 99);
        ok    = 1'b1;
        value = {$urandom, $urandom};
        if (pick < 6) begin
          ok = 1'b0;
          if ($urandom_range(0, 1) == 0) begin
            value = '0;
          end
        end else if (pick < 12) begin
          value = '0;
        end else if (pick < 52 && seen_values.size() > 0) begin
          value = seen_values[$urandom_range(0, seen_values.size() - 1)];
        end else if (value != '0) begin
          seen_values.push_back(value);
        end
        send_hit(value, ok, idle_on ? $urandom_range(0, 4) : 0);
      end
    end

    // Drain, then give the block a full search time to show any stray result.
    wait_idle();
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
